>>> src/dtfp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the double to fixed-point converter
package dtfp_pkg;

  // binary64 layout
  localparam int unsigned ExpW   = 11;
  localparam int unsigned MantW  = 52;
  localparam int unsigned SigW   = MantW + 1;
  localparam int unsigned ValueW = 64;

  // exponent at and above which the magnitude reaches 2^52 (also covers nan and inf)
  localparam logic [ExpW-1:0] ExpIntLimit = 11'd1075;

  // result widths
  localparam int unsigned IntW  = 32;
  localparam int unsigned FracW = 52;

  // configuration
  localparam int unsigned DigW    = 6;
  localparam int unsigned CfgIdxW = 4;

  localparam logic [DigW-1:0] FracDigitsMax = 6'd52;
  localparam logic [DigW-1:0] IntDigitsRst  = 6'd16;
  localparam logic [DigW-1:0] FracDigitsRst = 6'd16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgIntDigits  = 4'd0,
    CfgFracDigits = 4'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [DigW-1:0] int_digits;
    logic [DigW-1:0] frac_digits;
  } cfg_t;

  // after exponent decode: value = sig * 2^-rsh
  typedef struct packed {
    logic            neg;
    logic            oor;
    logic [SigW-1:0] sig;
    logic [ExpW-1:0] rsh;
  } dec_t;

  // after alignment: integer magnitude and the first 52 fraction bits
  typedef struct packed {
    logic             neg;
    logic             oor;
    logic [IntW-1:0]  mag;
    logic [FracW-1:0] frac;
  } aln_t;

endpackage

>>> src/dtfp_decode.sv
`timescale 1ns / 1ps
// stage 1: exponent decode, special values, hidden bit and right-shift amount
module dtfp_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [dtfp_pkg::ValueW-1:0] value_bits_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output dtfp_pkg::dec_t              dec_o
);
  import dtfp_pkg::*;

  logic            valid_q;
  dec_t            dec_d, dec_q;
  logic [ExpW-1:0] exp_raw;
  logic [ExpW-1:0] exp_eff;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign dec_o   = dec_q;

  always_comb begin
    exp_raw = value_bits_i[ValueW-2 -: ExpW];
    // subnormals use exponent one with no hidden bit
    exp_eff = (exp_raw == '0) ? ExpW'(1) : exp_raw;
    dec_d.neg = value_bits_i[ValueW-1];
    dec_d.oor = (exp_raw >= ExpIntLimit);
    dec_d.sig = {(exp_raw != '0), value_bits_i[MantW-1:0]};
    dec_d.rsh = ExpIntLimit - exp_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      dec_q <= dec_d;
    end
  end

endmodule

>>> src/dtfp_align.sv
`timescale 1ns / 1ps
// stage 2: barrel shift of the significand and 32-bit range check
module dtfp_align (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  dtfp_pkg::dec_t dec_i,
  output logic           valid_o,
  input  logic           ready_i,
  output dtfp_pkg::aln_t aln_o
);
  import dtfp_pkg::*;

  logic                  valid_q;
  aln_t                  aln_d, aln_q;
  logic [SigW+FracW-1:0] wide;
  logic [SigW-1:0]       mag_full;
  logic                  pos_big, neg_big;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign aln_o   = aln_q;

  always_comb begin
    // one shifter gives both the integer part and the first 52 fraction bits
    wide     = {dec_i.sig, {FracW{1'b0}}} >> dec_i.rsh;
    mag_full = wide[SigW+FracW-1:FracW];
    // positive limit 2^31-1, negative limit 2^31
    pos_big  = (mag_full[SigW-1:IntW-1] != '0);
    neg_big  = (mag_full[SigW-1:IntW] != '0) ||
               (mag_full[IntW-1] && (mag_full[IntW-2:0] != '0));
    aln_d.neg  = dec_i.neg;
    aln_d.oor  = dec_i.oor || (dec_i.neg ? neg_big : pos_big);
    aln_d.mag  = mag_full[IntW-1:0];
    aln_d.frac = wide[FracW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      aln_q <= aln_d;
    end
  end

endmodule

>>> src/dtfp_pack.sv
`timescale 1ns / 1ps
// stage 3: sign, digit masks and the output register
module dtfp_pack (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  dtfp_pkg::aln_t             aln_i,
  input  dtfp_pkg::cfg_t             cfg_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [dtfp_pkg::IntW-1:0]  int_part_o,
  output logic [dtfp_pkg::FracW-1:0] frac_part_o,
  output logic                       out_of_range_o
);
  import dtfp_pkg::*;

  logic             valid_q;
  logic [IntW-1:0]  int_d, int_q;
  logic [FracW-1:0] frac_d, frac_q;
  logic             oor_q;
  logic [IntW-1:0]  signed_int;
  logic [IntW-1:0]  int_mask;
  logic [DigW-1:0]  frac_dig;
  logic [DigW-1:0]  frac_sh;

  assign ready_o        = !valid_q || ready_i;
  assign valid_o        = valid_q;
  assign int_part_o     = int_q;
  assign frac_part_o    = frac_q;
  assign out_of_range_o = oor_q;

  always_comb begin
    signed_int = aln_i.neg ? (IntW'(0) - aln_i.mag) : aln_i.mag;
    // a shift of 32 or more clears the shifted ones, so counts of 32 or more keep all bits
    int_mask   = ~({IntW{1'b1}} << cfg_i.int_digits);
    frac_dig   = (cfg_i.frac_digits > FracDigitsMax) ? FracDigitsMax : cfg_i.frac_digits;
    frac_sh    = FracDigitsMax - frac_dig;
    if (aln_i.oor) begin
      int_d  = '0;
      frac_d = '0;
    end else begin
      int_d  = signed_int & int_mask;
      // negative values give no fraction
      frac_d = aln_i.neg ? '0 : (aln_i.frac >> frac_sh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      int_q  <= int_d;
      frac_q <= frac_d;
      oor_q  <= aln_i.oor;
    end
  end

endmodule

>>> src/double_to_fixed_point_bits.sv
`timescale 1ns / 1ps
// top level of the binary64 to fixed-point converter
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------------------
//  in      | into      | in_valid_i / in_ready_o  | value_bits_i[63:0]
//  out     | out of    | out_valid_o/ out_ready_i | int_part_o[31:0], frac_part_o[51:0],
//          |           |                          | out_of_range_o
//  cfg     | into      | cfg_valid_i/ cfg_ready_o | cfg_index_i[3:0], cfg_value_i[5:0]
//
// three register stages: decode, align (one 105-bit barrel shift), pack (output register)
// out_valid_o rises once an accepted input has passed the decode, align and pack registers;
// one item per cycle while out_ready_i does not stall the output
// a stage takes a new item whenever it is empty or its content moves on in the same cycle
// a stall on the output holds every full stage; nothing is dropped or repeated
// reset clears the valid bits and sets both digit counts to sixteen
// cfg_ready_o is always high; a write to an unknown index is taken and ignored
module double_to_fixed_point_bits (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dtfp_pkg::ValueW-1:0]   value_bits_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dtfp_pkg::IntW-1:0]     int_part_o,
  output logic [dtfp_pkg::FracW-1:0]    frac_part_o,
  output logic                          out_of_range_o,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dtfp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dtfp_pkg::DigW-1:0]     cfg_value_i
);
  import dtfp_pkg::*;

  cfg_t cfg_q;

  // stage-to-stage handshakes
  logic dec_valid, dec_ready;
  logic aln_valid, aln_ready;
  dec_t dec;
  aln_t aln;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.int_digits  <= IntDigitsRst;
      cfg_q.frac_digits <= FracDigitsRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgIntDigits:  cfg_q.int_digits  <= cfg_value_i;
        CfgFracDigits: cfg_q.frac_digits <= cfg_value_i;
        default: ;
      endcase
    end
  end

  // stage 1: sign, exponent, hidden bit, shift amount
  dtfp_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .ready_o      (in_ready_o),
    .value_bits_i (value_bits_i),
    .valid_o      (dec_valid),
    .ready_i      (dec_ready),
    .dec_o        (dec)
  );

  // stage 2: alignment and range check
  dtfp_align u_align (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .dec_i   (dec),
    .valid_o (aln_valid),
    .ready_i (aln_ready),
    .aln_o   (aln)
  );

  // stage 3: two's complement, digit masks, output register
  dtfp_pack u_pack (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (aln_valid),
    .ready_o        (aln_ready),
    .aln_i          (aln),
    .cfg_i          (cfg_q),
    .valid_o        (out_valid_o),
    .ready_i        (out_ready_i),
    .int_part_o     (int_part_o),
    .frac_part_o    (frac_part_o),
    .out_of_range_o (out_of_range_o)
  );

`ifndef NO_ASSERTIONS
  // an out-of-range result carries no digits
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (int_part_o == '0 && frac_part_o == '0))
    else $error("out-of-range result with nonzero digits");

  // integer part never exceeds the configured digit count
  a_int_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((int_part_o >> cfg_q.int_digits) == '0))
    else $error("integer part wider than int_digits");

  // fraction never exceeds the configured digit count
  a_frac_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((frac_part_o >> cfg_q.frac_digits) == '0))
    else $error("fraction part wider than frac_digits");
`endif

endmodule
